FILE: rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("implication failed");

`endif

FILE: rtl/dlc_pkg.sv
package dlc_pkg;

	// timer width default and register widths
	localparam int DLC_TIMER_BITS = 16;
	localparam int CFG_TIMER_W    = 16;
	localparam int FAIL_W         = 4;
	localparam int CMD_W          = 3;
	localparam int EVENT_W        = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;

	localparam logic [FAIL_W-1:0] FAIL_CAP = 4'd15;

	// register reset values
	localparam logic [FAIL_W-1:0]      RST_MAX_FAILURES   = 4'd5;
	localparam logic [CFG_TIMER_W-1:0] RST_UNUSED_OPEN    = 16'd10000;
	localparam logic [CFG_TIMER_W-1:0] RST_DOOR_OPEN_LIM  = 16'd30000;
	localparam logic [CFG_TIMER_W-1:0] RST_CHECK_PERIOD   = 16'd1000;
	localparam logic [CFG_TIMER_W-1:0] RST_EMERGENCY_WIN  = 16'd20000;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK       = 3'd0,
		CMD_OPEN       = 3'd1,
		CMD_CLOSE      = 3'd2,
		CMD_FAIL       = 3'd3,
		CMD_RESET_FAIL = 3'd4,
		CMD_APP_UNLOCK = 3'd5,
		CMD_EMERGENCY  = 3'd6
	} cmd_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE      = 3'd0,
		EV_OPENED    = 3'd1,
		EV_CLOSED    = 3'd2,
		EV_WARNING   = 3'd3,
		EV_LOCKOUT   = 3'd4,
		EV_UNLOCKED  = 3'd5,
		EV_ALERT_ON  = 3'd6,
		EV_ALERT_OFF = 3'd7
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_FAILURES = 3'd0,
		REG_UNUSED_OPEN  = 3'd1,
		REG_DOOR_LIMIT   = 3'd2,
		REG_CHECK_PERIOD = 3'd3,
		REG_EMERGENCY    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [FAIL_W-1:0]      max_failures;
		logic [CFG_TIMER_W-1:0] unused_open_ms;
		logic [CFG_TIMER_W-1:0] door_open_limit_ms;
		logic [CFG_TIMER_W-1:0] check_period_ms;
		logic [CFG_TIMER_W-1:0] emergency_alert_ms;
	} cfg_t;

endpackage

FILE: rtl/dlc_cfg.sv
module dlc_cfg
	import dlc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// register file, one register written per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_failures       <= RST_MAX_FAILURES;
			cfg_q.unused_open_ms     <= RST_UNUSED_OPEN;
			cfg_q.door_open_limit_ms <= RST_DOOR_OPEN_LIM;
			cfg_q.check_period_ms    <= RST_CHECK_PERIOD;
			cfg_q.emergency_alert_ms <= RST_EMERGENCY_WIN;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_MAX_FAILURES: cfg_q.max_failures       <= wr_data[FAIL_W-1:0];
				REG_UNUSED_OPEN:  cfg_q.unused_open_ms     <= wr_data[CFG_TIMER_W-1:0];
				REG_DOOR_LIMIT:   cfg_q.door_open_limit_ms <= wr_data[CFG_TIMER_W-1:0];
				REG_CHECK_PERIOD: cfg_q.check_period_ms    <= wr_data[CFG_TIMER_W-1:0];
				REG_EMERGENCY:    cfg_q.emergency_alert_ms <= wr_data[CFG_TIMER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/door_lock_controller_top.sv
// Door lock controller: takes one command beat per cycle when not stalled (millisecond tick,
// open, close, failed attempt, reset attempts, app unlock, emergency lock, with the door
// sensor level) and returns exactly one result beat per command carrying the lock drive, the
// alarm, the door alert and lockout flags, the failure count and an event code. The command
// lands in the input register at the accepting edge and the single-pass state update fills
// the result register once that register is free to advance. A stalled result holds the
// input register, so at most two commands are in flight. Timers are TIMER_BITS wide and
// saturate. Registers (index: reset) are max_failures 0: 5, unused_open_ms 1: 10000,
// door_open_limit_ms 2: 30000, check_period_ms 3: 1000, emergency_alert_ms 4: 20000;
// write them only while no command is in flight.
`include "assert_macros.svh"

module door_lock_controller_top
	import dlc_pkg::*;
#(
	parameter int TIMER_BITS = DLC_TIMER_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CMD_W-1:0]      cmd,
	input  logic                  door_open,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  lock_drive,
	output logic                  alert_on,
	output logic                  door_alert_active,
	output logic                  lockout_active,
	output logic [FAIL_W-1:0]     failure_count,
	output logic [EVENT_W-1:0]    event_res,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int TW = TIMER_BITS;
	localparam int CW = (TIMER_BITS > CFG_TIMER_W) ? TIMER_BITS : CFG_TIMER_W;

	cfg_t cfg;

	// configuration registers
	assign cfg_ready = 1'b1;

	dlc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// pipeline control
	logic valid_s1;
	cmd_t cmd_s1;
	logic door_s1;
	logic advance;
	logic out_valid_s2;

	assign advance  = !out_valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// input stage fills whenever it is empty or its beat moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= cmd_t'(cmd);
			door_s1 <= door_open;
		end
	end

	// controller state
	logic              lock_q, used_q, alert_q, lockout_q;
	logic [FAIL_W-1:0] fail_q;
	logic [TW-1:0]     unused_tmr_q, door_tmr_q, check_tmr_q, lockout_tmr_q;

	logic              n_lock, n_used, n_alert, n_lockout;
	logic [FAIL_W-1:0] n_fail;
	logic [TW-1:0]     n_unused_tmr, n_door_tmr, n_check_tmr, n_lockout_tmr;
	event_t            n_ev;
	logic              n_alarm;

	// single-pass command update
	always_comb begin
		n_lock        = lock_q;
		n_used        = used_q;
		n_alert       = alert_q;
		n_lockout     = lockout_q;
		n_fail        = fail_q;
		n_unused_tmr  = unused_tmr_q;
		n_door_tmr    = door_tmr_q;
		n_check_tmr   = check_tmr_q;
		n_lockout_tmr = lockout_tmr_q;
		n_ev          = EV_NONE;
		case (cmd_s1)
			CMD_TICK: begin
				n_unused_tmr  = (&unused_tmr_q)  ? unused_tmr_q  : unused_tmr_q  + TW'(1);
				n_door_tmr    = (&door_tmr_q)    ? door_tmr_q    : door_tmr_q    + TW'(1);
				n_check_tmr   = (&check_tmr_q)   ? check_tmr_q   : check_tmr_q   + TW'(1);
				n_lockout_tmr = (&lockout_tmr_q) ? lockout_tmr_q : lockout_tmr_q + TW'(1);
				if (lock_q && !door_s1 && !used_q &&
				    CW'(n_unused_tmr) >= CW'(cfg.unused_open_ms)) begin
					// opened but never used: relock
					n_lock  = 1'b0;
					n_alert = 1'b0;
					n_used  = 1'b0;
					n_ev    = EV_CLOSED;
				end else begin
					// first sight of the door open
					if (lock_q && door_s1 && !used_q) begin
						n_door_tmr = '0;
						n_used     = 1'b1;
					end
					// periodic door-open-too-long check
					if (CW'(n_check_tmr) >= CW'(cfg.check_period_ms)) begin
						n_check_tmr = '0;
						if (door_s1 && CW'(n_door_tmr) >= CW'(cfg.door_open_limit_ms)) begin
							if (!alert_q) begin
								n_alert = 1'b1;
								n_ev    = EV_ALERT_ON;
							end
						end else if (!door_s1 && alert_q) begin
							n_alert = 1'b0;
							n_ev    = EV_ALERT_OFF;
						end
					end
					// used door shut again: relock
					if (lock_q && !door_s1 && n_used) begin
						n_lock  = 1'b0;
						n_alert = 1'b0;
						n_used  = 1'b0;
						n_ev    = EV_CLOSED;
					end
				end
			end
			CMD_OPEN: begin
				if (!lockout_q) begin
					n_lock       = 1'b1;
					n_alert      = 1'b0;
					n_used       = 1'b0;
					n_unused_tmr = '0;
					n_fail       = '0;
					n_ev         = EV_OPENED;
				end
			end
			CMD_CLOSE: begin
				n_lock  = 1'b0;
				n_alert = 1'b0;
				n_used  = 1'b0;
				n_ev    = EV_CLOSED;
			end
			CMD_FAIL: begin
				if (!lockout_q) begin
					n_fail = (fail_q == FAIL_CAP) ? fail_q : fail_q + FAIL_W'(1);
					if (n_fail >= cfg.max_failures) begin
						n_lockout     = 1'b1;
						n_lockout_tmr = '0;
						n_ev          = EV_LOCKOUT;
					end else begin
						n_ev = EV_WARNING;
					end
				end
			end
			CMD_RESET_FAIL: begin
				n_fail = '0;
			end
			CMD_APP_UNLOCK: begin
				n_lockout     = 1'b0;
				n_lockout_tmr = '0;
				n_fail        = '0;
				n_ev          = EV_UNLOCKED;
			end
			CMD_EMERGENCY: begin
				if (!lockout_q) begin
					n_lockout     = 1'b1;
					n_lockout_tmr = '0;
					n_ev          = EV_LOCKOUT;
				end
			end
			default: begin
			end
		endcase
		n_alarm = n_alert ||
			(n_lockout && CW'(n_lockout_tmr) < CW'(cfg.emergency_alert_ms));
	end

	logic step;
	assign step = valid_s1 && advance;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q        <= 1'b0;
			used_q        <= 1'b0;
			alert_q       <= 1'b0;
			lockout_q     <= 1'b0;
			fail_q        <= '0;
			unused_tmr_q  <= '0;
			door_tmr_q    <= '0;
			check_tmr_q   <= '0;
			lockout_tmr_q <= '0;
		end else if (step) begin
			lock_q        <= n_lock;
			used_q        <= n_used;
			alert_q       <= n_alert;
			lockout_q     <= n_lockout;
			fail_q        <= n_fail;
			unused_tmr_q  <= n_unused_tmr;
			door_tmr_q    <= n_door_tmr;
			check_tmr_q   <= n_check_tmr;
			lockout_tmr_q <= n_lockout_tmr;
		end
	end

	// result register
	logic              lock_s2, alarm_s2, alert_s2, lockout_s2;
	logic [FAIL_W-1:0] fail_s2;
	event_t            ev_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			lock_s2    <= n_lock;
			alarm_s2   <= n_alarm;
			alert_s2   <= n_alert;
			lockout_s2 <= n_lockout;
			fail_s2    <= n_fail;
			ev_s2      <= n_ev;
		end
	end

	assign out_valid         = out_valid_s2;
	assign lock_drive        = lock_s2;
	assign alert_on          = alarm_s2;
	assign door_alert_active = alert_s2;
	assign lockout_active    = lockout_s2;
	assign failure_count     = fail_s2;
	assign event_res         = ev_s2;

	// checks
	`ASSERT_IMPL(a_stall_needs_item, clk, arst_n, in_stall, valid_s1 && out_valid_s2)
	`ASSERT_IMPL(a_lockout_restarts_window, clk, arst_n, $rose(lockout_q), lockout_tmr_q == '0)
	`ASSERT_IMPL(a_opened_drives_lock, clk, arst_n, out_valid_s2 && ev_s2 == EV_OPENED,
		lock_s2 && fail_s2 == '0)
	`ASSERT_IMPL(a_lockout_event_flag, clk, arst_n, out_valid_s2 && ev_s2 == EV_LOCKOUT,
		lockout_s2)
	`ASSERT_IMPL(a_door_alert_sounds, clk, arst_n, out_valid_s2 && alert_s2, alarm_s2)

endmodule

FILE: dv/door_lock_controller_checker.sv
`timescale 1ns / 1ps

module door_lock_controller_checker
	import dlc_pkg::*;
#(
	parameter int TIMER_BITS = DLC_TIMER_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [CMD_W-1:0]      cmd,
	input  logic                  door_open,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  lock_drive,
	input  logic                  alert_on,
	input  logic                  door_alert_active,
	input  logic                  lockout_active,
	input  logic [FAIL_W-1:0]     failure_count,
	input  logic [EVENT_W-1:0]    event_res,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           errors,
	output int unsigned           backlog
);

	typedef logic [TIMER_BITS-1:0] tmr_t;

	typedef struct packed {
		logic              lock;
		logic              alert;
		logic              door_alrt;
		logic              locked_out;
		logic [FAIL_W-1:0] fails;
		event_t            ev;
	} lock_status_t;

	// settings copy
	logic [FAIL_W-1:0]      lim_fail;
	logic [CFG_TIMER_W-1:0] lim_unused;
	logic [CFG_TIMER_W-1:0] lim_door;
	logic [CFG_TIMER_W-1:0] period_check;
	logic [CFG_TIMER_W-1:0] win_emerg;

	// lock state copy
	logic              lock_open;
	logic              door_used;
	logic              door_alrt;
	logic              locked_out;
	logic [FAIL_W-1:0] fail_cnt;
	tmr_t              unused_tmr;
	tmr_t              door_tmr;
	tmr_t              check_tmr;
	tmr_t              lockout_tmr;

	lock_status_t status_q[$];
	lock_status_t want;
	int unsigned  err_cnt;

	function automatic tmr_t bump(tmr_t t);
		return (t == '1) ? t : t + 1'b1;
	endfunction

	function automatic void shut_lock();
		lock_open = 1'b0;
		door_alrt = 1'b0;
		door_used = 1'b0;
	endfunction

	function automatic void begin_lockout();
		locked_out  = 1'b1;
		lockout_tmr = '0;
	endfunction

	// apply one command beat and return the status beat it should produce
	function automatic lock_status_t step_lock(logic [CMD_W-1:0] c, logic door);
		event_t       ev;
		lock_status_t r;
		ev = EV_NONE;
		case (c)
			CMD_TICK: begin
				unused_tmr  = bump(unused_tmr);
				door_tmr    = bump(door_tmr);
				check_tmr   = bump(check_tmr);
				lockout_tmr = bump(lockout_tmr);
				if (lock_open && !door && !door_used && unused_tmr >= lim_unused) begin
					shut_lock();
					ev = EV_CLOSED;
				end else begin
					if (lock_open && door && !door_used) begin
						door_tmr  = '0;
						door_used = 1'b1;
					end
					// periodic door-open-too-long check
					if (check_tmr >= period_check) begin
						check_tmr = '0;
						if (door && door_tmr >= lim_door) begin
							if (!door_alrt) begin
								door_alrt = 1'b1;
								ev = EV_ALERT_ON;
							end
						end else if (!door && door_alrt) begin
							door_alrt = 1'b0;
							ev = EV_ALERT_OFF;
						end
					end
					if (lock_open && !door && door_used) begin
						shut_lock();
						ev = EV_CLOSED;
					end
				end
			end
			CMD_OPEN: begin
				if (!locked_out) begin
					lock_open  = 1'b1;
					door_alrt  = 1'b0;
					door_used  = 1'b0;
					unused_tmr = '0;
					fail_cnt   = '0;
					ev = EV_OPENED;
				end
			end
			CMD_CLOSE: begin
				shut_lock();
				ev = EV_CLOSED;
			end
			CMD_FAIL: begin
				if (!locked_out) begin
					if (fail_cnt != FAIL_CAP)
						fail_cnt = fail_cnt + 1'b1;
					if (fail_cnt >= lim_fail) begin
						begin_lockout();
						ev = EV_LOCKOUT;
					end else begin
						ev = EV_WARNING;
					end
				end
			end
			CMD_RESET_FAIL: begin
				fail_cnt = '0;
			end
			CMD_APP_UNLOCK: begin
				locked_out  = 1'b0;
				lockout_tmr = '0;
				fail_cnt    = '0;
				ev = EV_UNLOCKED;
			end
			CMD_EMERGENCY: begin
				if (!locked_out) begin
					begin_lockout();
					ev = EV_LOCKOUT;
				end
			end
			default: begin
			end
		endcase
		r.lock       = lock_open;
		r.alert      = door_alrt || (locked_out && lockout_tmr < win_emerg);
		r.door_alrt  = door_alrt;
		r.locked_out = locked_out;
		r.fails      = fail_cnt;
		r.ev         = ev;
		return r;
	endfunction

	function automatic int field_bad(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			return 1;
		end
		return 0;
	endfunction

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_fail     = RST_MAX_FAILURES;
			lim_unused   = RST_UNUSED_OPEN;
			lim_door     = RST_DOOR_OPEN_LIM;
			period_check = RST_CHECK_PERIOD;
			win_emerg    = RST_EMERGENCY_WIN;
			lock_open    = 1'b0;
			door_used    = 1'b0;
			door_alrt    = 1'b0;
			locked_out   = 1'b0;
			fail_cnt     = '0;
			unused_tmr   = '0;
			door_tmr     = '0;
			check_tmr    = '0;
			lockout_tmr  = '0;
			status_q.delete();
			err_cnt = 0;
			errors  <= 0;
			backlog <= 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_FAILURES: lim_fail     = cfg_data[FAIL_W-1:0];
					REG_UNUSED_OPEN:  lim_unused   = cfg_data;
					REG_DOOR_LIMIT:   lim_door     = cfg_data;
					REG_CHECK_PERIOD: period_check = cfg_data;
					REG_EMERGENCY:    win_emerg    = cfg_data;
					default: begin
					end
				endcase
			end
			// command beat
			if (in_valid && !in_stall)
				status_q.push_back(step_lock(cmd, door_open));
			// status beat
			if (out_valid && !out_stall) begin
				if (status_q.size() == 0) begin
					$error("status beat with no command outstanding");
					err_cnt++;
				end else begin
					want = status_q.pop_front();
					err_cnt += field_bad("lock_drive", want.lock, lock_drive);
					err_cnt += field_bad("alert_on", want.alert, alert_on);
					err_cnt += field_bad("door_alert_active", want.door_alrt, door_alert_active);
					err_cnt += field_bad("lockout_active", want.locked_out, lockout_active);
					err_cnt += field_bad("failure_count", want.fails, failure_count);
					err_cnt += field_bad("event_res", want.ev, event_res);
				end
			end
			errors  <= err_cnt;
			backlog <= status_q.size();
		end
	end

endmodule

FILE: dv/tb_door_lock_controller_top.sv
`timescale 1ns / 1ps

module tb_door_lock_controller_top;
	import dlc_pkg::*;

	localparam logic [CMD_W-1:0]     CMD_UNUSED  = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
	localparam int                   PHASE_BEATS = 240;
	localparam int                   HOLD_CYCLES = 80;
	localparam int unsigned          CYCLE_LIMIT = 500000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid;
	logic                  in_stall;
	logic [CMD_W-1:0]      cmd;
	logic                  door_open;
	logic                  out_valid;
	logic                  out_stall;
	logic                  lock_drive;
	logic                  alert_on;
	logic                  door_alert_active;
	logic                  lockout_active;
	logic [FAIL_W-1:0]     failure_count;
	logic [EVENT_W-1:0]    event_res;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned chk_errors;
	int unsigned chk_backlog;

	// sender and receiver pacing
	logic        hold_go = 1'b0;
	logic        hold_done = 1'b0;
	int          hold_cnt = 0;
	int          seg_left = 0;
	int          stall_mode = 0;
	int          burst_left = 0;
	logic        no_gaps = 1'b0;
	logic        door_state = 1'b0;
	int unsigned beats = 0;
	int unsigned cycles = 0;

	always #5 clk = ~clk;

	door_lock_controller_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.door_open(door_open),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.lock_drive(lock_drive),
		.alert_on(alert_on),
		.door_alert_active(door_alert_active),
		.lockout_active(lockout_active),
		.failure_count(failure_count),
		.event_res(event_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	door_lock_controller_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.door_open(door_open),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.lock_drive(lock_drive),
		.alert_on(alert_on),
		.door_alert_active(door_alert_active),
		.lockout_active(lockout_active),
		.failure_count(failure_count),
		.event_res(event_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(chk_errors),
		.backlog(chk_backlog)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver stall pattern, with one long hold when requested
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				out_stall = 1'b1;
				hold_cnt++;
				if (hold_cnt >= HOLD_CYCLES)
					hold_done = 1'b1;
			end else begin
				if (seg_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					seg_left   = $urandom_range(5, 40);
				end
				seg_left--;
				case (stall_mode)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 3) == 0);
					2: out_stall = $urandom_range(0, 1);
					default: out_stall = ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// offer one command beat, pausing between bursts
	task automatic send_beat(logic [CMD_W-1:0] c, logic d);
		int gap;
		int r;
		if (!no_gaps && burst_left == 0) begin
			r = $urandom_range(0, 9);
			gap = (r < 5) ? $urandom_range(0, 3) : (r < 9) ? $urandom_range(4, 8) :
				$urandom_range(12, 30);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid  = 1'b1;
		cmd       = c;
		door_open = d;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		beats++;
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		do @(negedge clk); while (chk_backlog != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic program_regs(logic [15:0] mf, logic [15:0] uo, logic [15:0] dl,
		logic [15:0] cp, logic [15:0] ea);
		wait_idle();
		write_reg(REG_MAX_FAILURES, mf);
		write_reg(REG_UNUSED_OPEN, uo);
		write_reg(REG_DOOR_LIMIT, dl);
		write_reg(REG_CHECK_PERIOD, cp);
		write_reg(REG_EMERGENCY, ea);
	endtask

	// mostly ticks with a slowly wandering door sensor
	task automatic random_beat();
		int r;
		logic [CMD_W-1:0] c;
		r = $urandom_range(0, 99);
		if (r < 58) begin
			if ($urandom_range(0, 5) == 0)
				door_state = ~door_state;
			send_beat(CMD_TICK, door_state);
		end else begin
			if (r < 66)
				c = CMD_OPEN;
			else if (r < 71)
				c = CMD_CLOSE;
			else if (r < 80)
				c = CMD_FAIL;
			else if (r < 85)
				c = CMD_RESET_FAIL;
			else if (r < 90)
				c = CMD_APP_UNLOCK;
			else if (r < 96)
				c = CMD_EMERGENCY;
			else
				c = CMD_UNUSED;
			send_beat(c, $urandom_range(0, 1));
		end
	endtask

	// open, maybe wait, walk through, shut the door
	task automatic door_visit();
		int n;
		send_beat(CMD_OPEN, $urandom_range(0, 1));
		n = $urandom_range(0, 3);
		repeat (n) send_beat(CMD_TICK, 1'b0);
		n = $urandom_range(1, 12);
		repeat (n) send_beat(CMD_TICK, 1'b1);
		n = $urandom_range(1, 4);
		repeat (n) send_beat(CMD_TICK, 1'b0);
		door_state = 1'b0;
	endtask

	// run of bad attempts, sometimes cleared by the app
	task automatic fail_run();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) send_beat(CMD_FAIL, $urandom_range(0, 1));
		if ($urandom_range(0, 1))
			send_beat(CMD_APP_UNLOCK, $urandom_range(0, 1));
	endtask

	task automatic run_phase(int unsigned count);
		int unsigned stop;
		int r;
		stop = beats + count;
		while (beats < stop) begin
			r = $urandom_range(0, 9);
			if (r < 2)
				door_visit();
			else if (r < 3)
				fail_run();
			else
				random_beat();
		end
	endtask

	initial begin
		in_valid  = 1'b0;
		cmd       = CMD_TICK;
		door_open = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MAX_FAILURES;
		cfg_data  = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed at reset settings
		send_beat(CMD_TICK, 1'b0);
		send_beat(CMD_TICK, 1'b1);
		send_beat(CMD_OPEN, 1'b0);
		send_beat(CMD_TICK, 1'b1);
		send_beat(CMD_TICK, 1'b0);
		send_beat(CMD_OPEN, 1'b1);
		send_beat(CMD_CLOSE, 1'b0);
		send_beat(CMD_CLOSE, 1'b1);
		repeat (4) send_beat(CMD_FAIL, 1'b0);
		send_beat(CMD_RESET_FAIL, 1'b1);
		repeat (5) send_beat(CMD_FAIL, 1'b1);
		send_beat(CMD_OPEN, 1'b0);
		send_beat(CMD_FAIL, 1'b0);
		send_beat(CMD_EMERGENCY, 1'b1);
		send_beat(CMD_TICK, 1'b1);
		send_beat(CMD_APP_UNLOCK, 1'b0);
		send_beat(CMD_EMERGENCY, 1'b0);
		send_beat(CMD_APP_UNLOCK, 1'b1);
		send_beat(CMD_UNUSED, 1'b1);

		// zero timers, single failure locks out
		program_regs(16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
		run_phase(PHASE_BEATS);

		// all-ones settings
		program_regs(16'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_phase(PHASE_BEATS);

		// long result hold while commands keep coming
		program_regs(16'd3, 16'd8, 16'd5, 16'd2, 16'd12);
		hold_go = 1'b1;
		no_gaps = 1'b1;
		while (!hold_done)
			random_beat();
		repeat (10) random_beat();
		no_gaps = 1'b0;
		run_phase(PHASE_BEATS);

		// stray register index, failure limit of zero from a wide write
		wait_idle();
		write_reg(REG_UNUSED, 16'h5A5A);
		program_regs(16'hFFF0, 16'd5, 16'd3, 16'd1, 16'd6);
		run_phase(PHASE_BEATS / 2);
		wait_idle();
		run_phase(PHASE_BEATS / 2);

		program_regs(16'd2, 16'd20, 16'd12, 16'd4, 16'd40);
		run_phase(PHASE_BEATS);

		repeat (3) begin
			program_regs($urandom_range(1, 6), $urandom_range(0, 30), $urandom_range(0, 20),
				$urandom_range(0, 6), $urandom_range(0, 50));
			run_phase(PHASE_BEATS);
		end

		wait_idle();
		repeat (8) @(negedge clk);
		if (chk_errors == 0 && chk_backlog == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
